>>> hw/rtl/fcw_pkg.sv
// ----------------------------------------------------------------------------
// Front coding word encoder package
// Shared constants, configuration register indexes and result types.
// ----------------------------------------------------------------------------
package fcw_pkg;

  // Number of leading bytes of the previous word that are kept for matching.
  localparam int unsigned MAX_PREFIX  = 31;
  localparam int unsigned IDX_W       = $clog2(MAX_PREFIX);
  localparam int unsigned PLEN_W      = $clog2(MAX_PREFIX + 1);

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 6;
  localparam logic [POS_W-1:0] POS_MAX = 6'd63;

  localparam int unsigned CNT_W       = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = 17'd131071;

  localparam int unsigned CAP_W       = 5;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd31;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd65000;

  // At most a control byte, one text byte and a terminator per transaction.
  localparam int unsigned RES_MAX     = 3;
  localparam int unsigned NUM_W       = 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_CONTROL = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  typedef enum logic [0:0] {
    CFG_PREFIX_CAP  = 1'b0,
    CFG_BLOCK_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic              new_block;
    logic              last;
  } fcw_result_t;

  // Results of one transaction, packed from index 0, num of them valid.
  typedef struct packed {
    logic [NUM_W-1:0]                num;
    fcw_result_t [RES_MAX-1:0]       res;
  } fcw_push_t;

endpackage

>>> hw/rtl/fcw_in_if.sv
// ----------------------------------------------------------------------------
// Front coding word encoder input channel
// One byte of a word per transaction, with end-of-word and empty-word flags.
// ----------------------------------------------------------------------------
interface fcw_in_if;
  logic                       valid;
  logic                       ready;
  logic [fcw_pkg::BYTE_W-1:0] value;
  logic                       last_of_word;
  logic                       empty_word;

  modport source (output valid, value, last_of_word, empty_word, input ready);
  modport sink   (input valid, value, last_of_word, empty_word, output ready);
endinterface

>>> hw/rtl/fcw_out_if.sv
// ----------------------------------------------------------------------------
// Front coding word encoder output channel
// One control or text byte per transaction.
// ----------------------------------------------------------------------------
interface fcw_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [fcw_pkg::BYTE_W-1:0] data_byte;
  logic                       new_block;
  logic                       last;

  modport source (output valid, kind, data_byte, new_block, last, input ready);
  modport sink   (input valid, kind, data_byte, new_block, last, output ready);
endinterface

>>> hw/rtl/front_coding_word_encoder.sv
// ----------------------------------------------------------------------------
// Front coding word encoder
// Encodes a sorted word list, one byte per transaction, into control bytes
// carrying the shared prefix length, suffix text and zero terminators.
// ----------------------------------------------------------------------------
// A byte enters an input register and is encoded there against the stored
// first bytes of the previous word; its results (none to three) go into a
// four-entry result queue that drains one result per cycle while the
// receiver is ready. The input side takes one byte per cycle as long as
// the queue has room for the results of the byte in the input register,
// so throughput is one byte per cycle for bytes that give at most one
// result while the receiver is ready. A byte passes the input register
// and the result queue before its results appear. Configuration must be
// written only while no transaction is in flight, unchecked by the block.
module front_coding_word_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  fcw_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [fcw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  fcw_in_if.sink                         in_i,
  fcw_out_if.source                      out_o
);

  logic                       inq_valid_q;
  logic [fcw_pkg::BYTE_W-1:0] inq_value_q;
  logic                       inq_last_q;
  logic                       inq_empty_q;
  logic                       take;
  logic [fcw_pkg::QCNT_W-1:0] free;
  fcw_pkg::fcw_push_t         push;
  fcw_pkg::fcw_result_t       res;

  assign take       = inq_valid_q && (fcw_pkg::QCNT_W'(push.num) <= free);
  assign in_i.ready = !inq_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      inq_value_q <= in_i.value;
      inq_last_q  <= in_i.last_of_word;
      inq_empty_q <= in_i.empty_word;
    end
  end

  fcw_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .value_i        (inq_value_q),
    .last_of_word_i (inq_last_q),
    .empty_word_i   (inq_empty_q),
    .take_i         (take),
    .push_o         (push)
  );

  fcw_res_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (take),
    .push_i    (push),
    .free_o    (free),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .res_o     (res)
  );

  assign out_o.kind      = res.kind;
  assign out_o.data_byte = res.data_byte;
  assign out_o.new_block = res.new_block;
  assign out_o.last      = res.last;

endmodule

>>> hw/rtl/fcw_core.sv
// ----------------------------------------------------------------------------
// Front coding word encoder core
// Holds the word and block state and turns one registered input byte
// combinationally into up to three results.
// ----------------------------------------------------------------------------
module fcw_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  fcw_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [fcw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [fcw_pkg::BYTE_W-1:0]    value_i,
  input  logic                          last_of_word_i,
  input  logic                          empty_word_i,
  input  logic                          take_i,
  output fcw_pkg::fcw_push_t            push_o
);

  logic [fcw_pkg::CAP_W-1:0]   prefix_cap_q;
  logic [fcw_pkg::LIMIT_W-1:0] limit_q;

  logic [fcw_pkg::BYTE_W-1:0] prev_q [fcw_pkg::MAX_PREFIX];
  logic [fcw_pkg::PLEN_W-1:0] prevlen_q, prevlen_d;
  logic [fcw_pkg::POS_W-1:0]  pos_q, pos_d;
  logic                       still_q, still_d;
  logic [fcw_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       open_q;
  logic                       wob_q, wob_d;

  logic                       start, ends, in_range;
  logic                       match_in, match_hit, matching_after;
  logic                       ctrl_a, text_b, ctrl_c;
  logic [fcw_pkg::PLEN_W-1:0] prevlen_eff;
  logic [fcw_pkg::CAP_W-1:0]  cap_eff;
  logic [fcw_pkg::CNT_W-1:0]  cnt_base;
  logic [fcw_pkg::CNT_W:0]    cnt_sum;
  logic [1:0]                 ntext;
  logic [fcw_pkg::POS_W-1:0]  pos_after;
  logic [fcw_pkg::IDX_W-1:0]  rd_idx;
  fcw_pkg::fcw_push_t         push;

  always_comb begin
    start    = (pos_q == '0);
    ends     = empty_word_i | last_of_word_i;
    in_range = (pos_q < fcw_pkg::POS_W'(fcw_pkg::MAX_PREFIX));
    rd_idx   = in_range ? fcw_pkg::IDX_W'(pos_q) : '0;
    cap_eff  = (prefix_cap_q < fcw_pkg::CAP_W'(fcw_pkg::MAX_PREFIX)) ?
               prefix_cap_q : fcw_pkg::CAP_W'(fcw_pkg::MAX_PREFIX);

    // A word opens a block when none is open or the block text has run full.
    match_in = start ? 1'b1 : still_q;
    wob_d    = start ? (!open_q || (count_q >= fcw_pkg::CNT_W'(limit_q))) : wob_q;
    prevlen_eff = (start && wob_d) ? '0 : prevlen_q;
    cnt_base    = (start && wob_d) ? '0 : count_q;

    match_hit = in_range &&
                (pos_q < fcw_pkg::POS_W'(prevlen_eff)) &&
                (pos_q < fcw_pkg::POS_W'(cap_eff)) &&
                (prev_q[rd_idx] == value_i);

    ctrl_a         = !empty_word_i && match_in && !match_hit;
    matching_after = empty_word_i ? match_in : (match_in && match_hit);
    text_b         = !empty_word_i && !matching_after;
    ctrl_c         = ends && matching_after;

    if (empty_word_i || pos_q == fcw_pkg::POS_MAX) begin
      pos_after = pos_q;
    end else begin
      pos_after = pos_q + fcw_pkg::POS_W'(1);
    end

    ntext   = {1'b0, text_b} + {1'b0, ends};
    cnt_sum = {1'b0, cnt_base} + (fcw_pkg::CNT_W + 1)'(ntext);
    count_d = (cnt_sum > {1'b0, fcw_pkg::CNT_MAX}) ? fcw_pkg::CNT_MAX :
              cnt_sum[fcw_pkg::CNT_W-1:0];

    if (ends) begin
      pos_d     = '0;
      still_d   = 1'b1;
      prevlen_d = (pos_after < fcw_pkg::POS_W'(fcw_pkg::MAX_PREFIX)) ?
                  fcw_pkg::PLEN_W'(pos_after) : fcw_pkg::PLEN_W'(fcw_pkg::MAX_PREFIX);
    end else begin
      pos_d     = pos_after;
      still_d   = matching_after;
      prevlen_d = prevlen_eff;
    end
  end

  // Pack the results of this transaction in order and mark the final one.
  always_comb begin
    push = '0;
    if (ctrl_a) begin
      push.res[push.num] = '{kind: fcw_pkg::KIND_CONTROL,
                             data_byte: fcw_pkg::BYTE_W'(pos_q),
                             new_block: wob_d, last: 1'b0};
      push.num = push.num + fcw_pkg::NUM_W'(1);
    end
    if (text_b) begin
      push.res[push.num] = '{kind: fcw_pkg::KIND_TEXT, data_byte: value_i,
                             new_block: wob_d, last: 1'b0};
      push.num = push.num + fcw_pkg::NUM_W'(1);
    end
    if (ctrl_c) begin
      push.res[push.num] = '{kind: fcw_pkg::KIND_CONTROL,
                             data_byte: fcw_pkg::BYTE_W'(pos_after),
                             new_block: wob_d, last: 1'b0};
      push.num = push.num + fcw_pkg::NUM_W'(1);
    end
    if (ends) begin
      push.res[push.num] = '{kind: fcw_pkg::KIND_TEXT, data_byte: '0,
                             new_block: wob_d, last: 1'b0};
      push.num = push.num + fcw_pkg::NUM_W'(1);
    end
    for (int i = 0; i < fcw_pkg::RES_MAX; i++) begin
      push.res[i].last = (fcw_pkg::NUM_W'(i) == push.num - fcw_pkg::NUM_W'(1));
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_cap_q <= fcw_pkg::CAP_RESET;
      limit_q      <= fcw_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcw_pkg::CFG_PREFIX_CAP:  prefix_cap_q <= cfg_wdata_i[fcw_pkg::CAP_W-1:0];
        fcw_pkg::CFG_BLOCK_LIMIT: limit_q      <= cfg_wdata_i[fcw_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prevlen_q <= '0;
      pos_q     <= '0;
      still_q   <= 1'b1;
      count_q   <= '0;
      open_q    <= 1'b0;
      wob_q     <= 1'b0;
    end else if (take_i) begin
      prevlen_q <= prevlen_d;
      pos_q     <= pos_d;
      still_q   <= still_d;
      count_q   <= count_d;
      open_q    <= open_q | start;
      wob_q     <= wob_d;
    end
  end

  // Entries are only read below the stored length, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (take_i && !empty_word_i && in_range) begin
      prev_q[rd_idx] <= value_i;
    end
  end

endmodule

>>> hw/rtl/fcw_res_queue.sv
// ----------------------------------------------------------------------------
// Front coding word encoder result queue
// Small circular buffer that takes up to three results per cycle and hands
// out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module fcw_res_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_en_i,
  input  fcw_pkg::fcw_push_t         push_i,
  output logic [fcw_pkg::QCNT_W-1:0] free_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output fcw_pkg::fcw_result_t       res_o
);

  fcw_pkg::fcw_result_t              mem_q [fcw_pkg::QUEUE_DEPTH];
  logic [fcw_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [fcw_pkg::QCNT_W-1:0]        count_q, count_d, push_cnt;
  logic                              pop;

  always_comb begin
    pop      = valid_o && ready_i;
    push_cnt = push_en_i ? fcw_pkg::QCNT_W'(push_i.num) : '0;
    wr_ptr_d = wr_ptr_q + fcw_pkg::QPTR_W'(push_cnt);
    rd_ptr_d = pop ? rd_ptr_q + fcw_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + push_cnt - (pop ? fcw_pkg::QCNT_W'(1) : '0);
  end

  assign free_o  = fcw_pkg::QCNT_W'(fcw_pkg::QUEUE_DEPTH) - count_q;
  assign valid_o = (count_q != '0);
  assign res_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < fcw_pkg::RES_MAX; i++) begin
      if (push_en_i && (fcw_pkg::NUM_W'(i) < push_i.num)) begin
        mem_q[wr_ptr_q + fcw_pkg::QPTR_W'(i)] <= push_i.res[i];
      end
    end
  end

endmodule

>>> test/tb_front_coding_word_encoder.sv
// ----------------------------------------------------------------------------
// Front coding word encoder testbench
// Streams sorted-ish word lists through the encoder under random idling on
// both channels, predicts every control and text byte with an independent
// model of the prefix matcher and block counter, and compares each result
// transaction field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_front_coding_word_encoder;
  import fcw_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 80;

  typedef logic [BYTE_W-1:0] word_t[$];

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  fcw_in_if  in_if ();
  fcw_out_if out_if ();

  front_coding_word_encoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Encoder state as the predictor sees it.
  logic [BYTE_W-1:0] prev_bytes [MAX_PREFIX];
  int unsigned       prev_len;
  int unsigned       word_pos;
  bit                match_pending;
  int unsigned       text_count;
  bit                block_open;
  bit                word_new_block;
  logic [CAP_W-1:0]  cap_reg;
  logic [LIMIT_W-1:0] limit_reg;

  fcw_result_t pending_results[$];
  fcw_result_t expected_q[$];

  int    error_count;
  int    items_sent;
  int    cycle_count;
  bit    tx_steady;
  bit    rx_steady;
  int    stall_requests;
  int    stalls_served;
  int    rx_hold_left;
  word_t prev_word;

  function automatic void reset_model();
    foreach (prev_bytes[i]) prev_bytes[i] = '0;
    prev_len       = 0;
    word_pos       = 0;
    match_pending  = 1'b1;
    text_count     = 0;
    block_open     = 1'b0;
    word_new_block = 1'b0;
    cap_reg        = CAP_RESET;
    limit_reg      = LIMIT_RESET;
  endfunction

  function automatic void push_result(input logic kind, input logic [BYTE_W-1:0] data);
    fcw_result_t r;
    r.kind      = kind;
    r.data_byte = data;
    r.new_block = word_new_block;
    r.last      = 1'b0;
    pending_results.push_back(r);
    if (kind == KIND_TEXT && text_count < CNT_MAX) text_count++;
  endfunction

  function automatic void encode_byte(input logic [BYTE_W-1:0] v, input logic eow,
                                      input logic empty);
    int unsigned cap_eff;
    int unsigned p;
    bit          hit;
    cap_eff = (cap_reg < MAX_PREFIX) ? cap_reg : MAX_PREFIX;
    pending_results.delete();
    if (word_pos == 0) begin
      match_pending = 1'b1;
      if (!block_open || text_count >= limit_reg) begin
        block_open     = 1'b1;
        text_count     = 0;
        prev_len       = 0;
        word_new_block = 1'b1;
      end else begin
        word_new_block = 1'b0;
      end
    end
    if (!empty) begin
      p = word_pos;
      if (match_pending) begin
        hit = 1'b0;
        if (p < prev_len && p < cap_eff && p < MAX_PREFIX) hit = (prev_bytes[p] == v);
        if (!hit) begin
          push_result(KIND_CONTROL, p[BYTE_W-1:0]);
          match_pending = 1'b0;
        end
      end
      if (!match_pending) push_result(KIND_TEXT, v);
      if (p < MAX_PREFIX) prev_bytes[p] = v;
      if (word_pos < POS_MAX) word_pos++;
    end
    // An empty-word flag closes the word no matter what last_of_word says.
    if (empty || eow) begin
      if (match_pending) push_result(KIND_CONTROL, word_pos[BYTE_W-1:0]);
      push_result(KIND_TEXT, '0);
      prev_len      = (word_pos < MAX_PREFIX) ? word_pos : MAX_PREFIX;
      word_pos      = 0;
      match_pending = 1'b1;
    end
    if (pending_results.size() > 0) pending_results[pending_results.size()-1].last = 1'b1;
    foreach (pending_results[i]) expected_q.push_back(pending_results[i]);
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 99) < 75) return BYTE_W'(8'h61 + $urandom_range(0, 3));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
             what, cycle_count, want, got);
    error_count++;
  endtask

  task automatic send_item(input logic [BYTE_W-1:0] v, input logic eow, input logic empty);
    int gap;
    gap = tx_steady ? 0 : rand_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.value        <= v;
    in_if.last_of_word <= eow;
    in_if.empty_word   <= empty;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    encode_byte(v, eow, empty);
    items_sent++;
  endtask

  task automatic send_word(input word_t w, input bit close_with_empty);
    for (int i = 0; i < w.size(); i++)
      send_item(w[i], (i == w.size() - 1) && !close_with_empty, 1'b0);
    if (close_with_empty || w.size() == 0)
      send_item(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Keeps a random share of the previous word and appends fresh bytes.
  task automatic build_word(output word_t w);
    int r, len, keep;
    r = $urandom_range(0, 99);
    if (r < 80) len = $urandom_range(1, 8);
    else if (r < 97) len = $urandom_range(9, 40);
    else len = $urandom_range(41, 66);
    keep = $urandom_range(0, (len < prev_word.size()) ? len : prev_word.size());
    w = {};
    for (int i = 0; i < keep; i++) w.push_back(prev_word[i]);
    while (w.size() < len) w.push_back(pick_byte());
    prev_word = w;
  endtask

  // Lets the encoder run dry before anything about its settings changes.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [CAP_W-1:0] cap, input logic [LIMIT_W-1:0] limit);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PREFIX_CAP;
    cfg_wdata_i <= CFG_DATA_W'(cap);
    @(posedge clk_i);
    cap_reg      = cap;
    cfg_idx_i   <= CFG_BLOCK_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    limit_reg    = limit;
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_words(input int n_items);
    int    start, r;
    word_t w;
    start = items_sent;
    while (items_sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        w.delete();
        prev_word.delete();
        send_word(w, 1'b0);
      end else begin
        build_word(w);
        send_word(w, r < 14);
      end
    end
  endtask

  task automatic test_directed_words();
    send_word('{8'h61, 8'h62}, 1'b0);
    send_word('{8'h61, 8'h62, 8'h63}, 1'b0);
    // A full repeat stays held back until the end of the word.
    send_word('{8'h61, 8'h62, 8'h63}, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
    send_word('{8'h00, 8'hFF}, 1'b0);
    send_word('{8'h00}, 1'b1);
  endtask

  task automatic test_config_extremes();
    apply_settings(5'd0, 16'd3);
    repeat (3) send_word('{8'h61, 8'h62}, 1'b0);
    apply_settings(5'd31, 16'd0);
    repeat (2) send_word('{8'h61}, 1'b0);
    apply_settings(5'd31, 16'hFFFF);
    send_word('{8'h78}, 1'b0);
    send_word('{8'h78, 8'h79}, 1'b0);
  endtask

  // The first word runs past the position counter's saturation point, the
  // second shares a prefix with it that reaches beyond the stored prefix depth.
  task automatic test_long_words();
    word_t w;
    for (int i = 0; i < 66; i++) w.push_back(pick_byte());
    send_word(w, 1'b0);
    w = w[0:33];
    send_word(w, 1'b0);
    prev_word = w;
  endtask

  task automatic test_input_stall();
    word_t w;
    apply_settings(5'd5, 16'd20);
    stall_requests++;
    tx_steady = 1'b1;
    for (int i = 0; i < 4; i++) begin
      build_word(w);
      send_word(w, 1'b0);
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_random_words();
    apply_settings(5'd31, 16'hFFFF);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_words(8);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    apply_settings(5'd3, 16'd12);
    random_words(8);
    apply_settings(CAP_W'($urandom_range(0, 31)), LIMIT_W'($urandom_range(1, 40)));
    random_words(8);
    apply_settings(5'd0, 16'd1);
    random_words(8);
    apply_settings(CAP_W'($urandom_range(0, 31)), LIMIT_W'($urandom_range(0, 65535)));
    random_words(8);
  endtask

  // Receiver: random stalls, plus one long hold-off when a test asks for it.
  always @(posedge clk_i) begin : rx_ready_ctrl
    int g;
    if (rst_ni) begin
      if (stall_requests != stalls_served) begin
        stalls_served = stall_requests;
        rx_hold_left  = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_if.ready <= 1'b0;
      end else if (rx_steady) begin
        out_if.ready <= 1'b1;
      end else begin
        g = rand_gap();
        if (g == 0) begin
          out_if.ready <= 1'b1;
        end else begin
          rx_hold_left  = g - 1;
          out_if.ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    fcw_result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction, data_byte", 0, out_if.data_byte);
      end else begin
        want = expected_q.pop_front();
        if (out_if.kind !== want.kind) report_mismatch("kind", want.kind, out_if.kind);
        if (out_if.data_byte !== want.data_byte)
          report_mismatch("data_byte", want.data_byte, out_if.data_byte);
        if (out_if.new_block !== want.new_block)
          report_mismatch("new_block", want.new_block, out_if.new_block);
        if (out_if.last !== want.last) report_mismatch("last", want.last, out_if.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_PREFIX_CAP;
    cfg_wdata_i        = '0;
    in_if.valid        = 1'b0;
    in_if.value        = '0;
    in_if.last_of_word = 1'b0;
    in_if.empty_word   = 1'b0;
    out_if.ready       = 1'b0;
    error_count        = 0;
    items_sent         = 0;
    cycle_count        = 0;
    tx_steady          = 1'b0;
    rx_steady          = 1'b0;
    stall_requests     = 0;
    stalls_served      = 0;
    rx_hold_left       = 0;
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_words();
    test_config_extremes();
    test_long_words();
    test_input_stall();
    test_random_words();

    settle();
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> front_coding_word_encoder.f
hw/rtl/fcw_pkg.sv
hw/rtl/fcw_in_if.sv
hw/rtl/fcw_out_if.sv
hw/rtl/fcw_core.sv
hw/rtl/fcw_res_queue.sv
hw/rtl/front_coding_word_encoder.sv
test/tb_front_coding_word_encoder.sv
